// File: design/rgb_channel_run_length_encoder_core_macros.svh
// Assertion macros for the RGB run-length encoder core.
// Included by the top level; each macro expects clk and rst in scope.
`ifndef RGB_CHANNEL_RUN_LENGTH_ENCODER_CORE_MACROS_SVH
`define RGB_CHANNEL_RUN_LENGTH_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RGBRLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgbrle: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RGBRLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgbrle: next-cycle check failed");

`endif

// File: design/rgbrle_pkg.sv
// Shared types and constants for the RGB run-length encoder core.
// No dependencies; every other design file but the macros header refers to it by scoped names.
`default_nettype none

package rgbrle_pkg;

  localparam int SEGMENT_PIXELS = 16;
  localparam int NUM_CH         = 3;
  localparam int PIX_W          = 8;
  localparam int LEN_W          = 5;
  localparam int IDX_W          = (SEGMENT_PIXELS > 1) ? $clog2(SEGMENT_PIXELS) : 1;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } channel_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [PIX_W-1:0] value;
  } run_t;

  // Pixel strobe from the sequencer to the lanes.
  typedef struct packed {
    logic take;
    logic first;
  } lane_ctrl_t;

  // Read request from the sequencer to the lanes.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } rd_req_t;

endpackage

`default_nettype wire

// File: design/rgbrle_if.sv
// Valid/ready channel interfaces: pixel input and run output.
// Depends on rgbrle_pkg for field widths.
`default_nettype none

interface rgbrle_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [rgbrle_pkg::PIX_W-1:0]  red;
  logic [rgbrle_pkg::PIX_W-1:0]  green;
  logic [rgbrle_pkg::PIX_W-1:0]  blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rgbrle_run_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    channel;
  logic [rgbrle_pkg::LEN_W-1:0]  run_length;
  logic [rgbrle_pkg::PIX_W-1:0]  run_value;
  logic                          segment_last;

  modport source (output valid, channel, run_length, run_value, segment_last, input ready);
  modport sink   (input valid, channel, run_length, run_value, segment_last, output ready);
endinterface

`default_nettype wire

// File: design/rgb_channel_run_length_encoder_core.sv
// RGB run-length encoder core, top level.
// Depends on rgbrle_pkg, rgbrle_if, rgbrle_lane, rgbrle_merge and the macros header.
//
// Usage:
//   pix  : one RGB888 pixel per beat (valid/ready). Pixels are grouped into
//          segments of rgbrle_pkg::SEGMENT_PIXELS.
//   runs : one (channel, run_length, run_value) beat per run. After the last
//          pixel of a segment, all red runs, then green, then blue, are sent
//          in arrival order; segment_last marks the final blue run.
//   Three lanes, one per color, track runs in parallel; a single pixel beat
//   is taken each cycle while a segment fills. Only the last pixel causes
//   results: it starts the readout, each run passes through the lane read
//   register and then the output register, then one run per cycle while
//   runs.ready is high. N pixels give at most 3N runs, read by the single
//   read port of each lane store and sent by the one-beat-per-cycle output.
//   pix.ready stays low while the runs of a segment are read out of the
//   lanes; the last two runs may still sit in the read and output registers.
//   A stall on runs holds the output register and the read stage; nothing
//   is dropped. Reset (rst, synchronous) empties both stages and starts a
//   new segment; no clearing pass is needed.
`default_nettype none
`include "rgb_channel_run_length_encoder_core_macros.svh"

module rgb_channel_run_length_encoder_core (
  input  wire         clk,
  input  wire         rst,
  rgbrle_pixel_if.sink pix,
  rgbrle_run_if.source runs
);

  rgbrle_pkg::lane_ctrl_t          ctrl;
  rgbrle_pkg::rd_req_t             rd;
  logic                            seg_end;
  logic [rgbrle_pkg::IDX_W-1:0]    pos   [rgbrle_pkg::NUM_CH];
  rgbrle_pkg::run_t                rdata [rgbrle_pkg::NUM_CH];
  logic [rgbrle_pkg::PIX_W-1:0]    sample [rgbrle_pkg::NUM_CH];
  rgbrle_pkg::channel_t            out_channel;
  rgbrle_pkg::run_t                out_run;

  assign sample[rgbrle_pkg::CH_RED]   = pix.red;
  assign sample[rgbrle_pkg::CH_GREEN] = pix.green;
  assign sample[rgbrle_pkg::CH_BLUE]  = pix.blue;

  for (genvar g = 0; g < rgbrle_pkg::NUM_CH; g++) begin : g_lane
    rgbrle_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .sample (sample[g]),
      .rd     (rd),
      .pos    (pos[g]),
      .rdata  (rdata[g])
    );
  end

  rgbrle_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (pix.valid),
    .in_ready    (pix.ready),
    .ctrl        (ctrl),
    .seg_end     (seg_end),
    .rd          (rd),
    .pos         (pos),
    .rdata       (rdata),
    .out_valid   (runs.valid),
    .out_ready   (runs.ready),
    .out_channel (out_channel),
    .out_run     (out_run),
    .out_last    (runs.segment_last)
  );

  assign runs.channel    = out_channel;
  assign runs.run_length = out_run.len;
  assign runs.run_value  = out_run.value;

  `RGBRLE_ASSERT_NOW(a_last_is_blue, runs.valid && runs.segment_last, out_channel == rgbrle_pkg::CH_BLUE)
  `RGBRLE_ASSERT_NOW(a_len_nonzero, runs.valid, out_run.len != '0)
  `RGBRLE_ASSERT_NEXT(a_hold_after_segment, ctrl.take && seg_end, !pix.ready)

endmodule

`default_nettype wire

// File: design/rgbrle_lane.sv
// One color lane: tracks the open run and stores closed runs of a segment.
// Depends on rgbrle_pkg; instantiated three times by the top level.
`default_nettype none

module rgbrle_lane (
  input  wire                            clk,
  input  wire                            rst,
  input  rgbrle_pkg::lane_ctrl_t         ctrl,
  input  wire [rgbrle_pkg::PIX_W-1:0]    sample,
  input  rgbrle_pkg::rd_req_t            rd,
  output logic [rgbrle_pkg::IDX_W-1:0]   pos,
  output rgbrle_pkg::run_t               rdata
);

  rgbrle_pkg::run_t               mem [rgbrle_pkg::SEGMENT_PIXELS];
  logic [rgbrle_pkg::LEN_W-1:0]   cur_len;
  logic [rgbrle_pkg::PIX_W-1:0]   cur_val;
  logic                           repeat_hit;

  assign repeat_hit = (sample == cur_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (ctrl.take) begin
      if (ctrl.first) begin
        pos <= '0;
      end else if (!repeat_hit) begin
        pos <= pos + rgbrle_pkg::IDX_W'(1);
      end
    end
  end

  // Open run lives in registers; close it into the store on a value change.
  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      if (ctrl.first || !repeat_hit) begin
        cur_len <= rgbrle_pkg::LEN_W'(1);
        cur_val <= sample;
      end else begin
        cur_len <= cur_len + rgbrle_pkg::LEN_W'(1);
      end
      if (!ctrl.first && !repeat_hit) begin
        mem[pos] <= '{len: cur_len, value: cur_val};
      end
    end
  end

  // Registered read; the open run stands at the current position.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      if (rd.idx == pos) begin
        rdata <= '{len: cur_len, value: cur_val};
      end else begin
        rdata <= mem[rd.idx];
      end
    end
  end

endmodule

`default_nettype wire

// File: design/rgbrle_merge.sv
// Segment sequencer and merge stage: counts pixels, then walks the lanes
// red, green, blue through a read stage into the output register.
// Depends on rgbrle_pkg.
`default_nettype none

module rgbrle_merge (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_ready,
  output rgbrle_pkg::lane_ctrl_t         ctrl,
  output logic                           seg_end,
  output rgbrle_pkg::rd_req_t            rd,
  input  wire [rgbrle_pkg::IDX_W-1:0]    pos   [rgbrle_pkg::NUM_CH],
  input  rgbrle_pkg::run_t               rdata [rgbrle_pkg::NUM_CH],
  output logic                           out_valid,
  input  wire                            out_ready,
  output rgbrle_pkg::channel_t           out_channel,
  output rgbrle_pkg::run_t               out_run,
  output logic                           out_last
);

  logic                           emitting;
  logic [rgbrle_pkg::IDX_W-1:0]   seg_count;
  rgbrle_pkg::channel_t           ch;
  logic [rgbrle_pkg::IDX_W-1:0]   k;
  logic                           rd_valid;
  rgbrle_pkg::channel_t           rd_ch;
  logic                           rd_last;
  logic                           load_out;
  logic                           issue;
  logic                           at_end;

  assign in_ready   = !emitting;
  assign ctrl.take  = in_valid && in_ready;
  assign ctrl.first = (seg_count == '0);
  assign seg_end    = (seg_count == rgbrle_pkg::IDX_W'(rgbrle_pkg::SEGMENT_PIXELS - 1));

  assign load_out = rd_valid && (!out_valid || out_ready);
  assign issue    = emitting && (!rd_valid || load_out);
  assign at_end   = (k == pos[ch]);
  assign rd.en    = issue;
  assign rd.idx   = k;

  always_ff @(posedge clk) begin
    if (rst) begin
      emitting  <= 1'b0;
      seg_count <= '0;
      ch        <= rgbrle_pkg::CH_RED;
      k         <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.take) begin
        if (seg_end) begin
          seg_count <= '0;
          emitting  <= 1'b1;
          ch        <= rgbrle_pkg::CH_RED;
          k         <= '0;
        end else begin
          seg_count <= seg_count + rgbrle_pkg::IDX_W'(1);
        end
      end
      if (issue) begin
        rd_valid <= 1'b1;
        if (at_end) begin
          k <= '0;
          if (ch == rgbrle_pkg::CH_BLUE) begin
            emitting <= 1'b0;
          end else begin
            ch <= rgbrle_pkg::channel_t'(ch + 2'd1);
          end
        end else begin
          k <= k + rgbrle_pkg::IDX_W'(1);
        end
      end else if (load_out) begin
        rd_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Tag travels with the read; payload moves only when the output frees up.
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_ch   <= ch;
      rd_last <= (ch == rgbrle_pkg::CH_BLUE) && at_end;
    end
    if (load_out) begin
      out_channel <= rd_ch;
      out_run     <= rdata[rd_ch];
      out_last    <= rd_last;
    end
  end

endmodule

`default_nettype wire
